FILE: rtl/core/trapezoid_velocity_profile_macros.svh
// Assertion macros for the trapezoid velocity profile block.
`ifndef TRAPEZOID_VELOCITY_PROFILE_MACROS_SVH
`define TRAPEZOID_VELOCITY_PROFILE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define TVP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TVP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TVP_ASSERT_IMP(label, ante, cons, msg)
`define TVP_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/core/tvp_pkg.sv
// Shared types and constants for the trapezoid velocity profile block.
package tvp_pkg;

  // serial multiply/divide unit geometry
  localparam int unsigned MD_AW = 48;  // multiplicand
  localparam int unsigned MD_BW = 32;  // multiplier, one bit per cycle
  localparam int unsigned MD_DW = 37;  // divisor
  localparam int unsigned MD_RW = 38;  // partial remainder
  localparam int unsigned MD_NW = 80;  // dividend / product
  localparam int unsigned MD_QW = 64;  // quotient
  localparam int unsigned MD_CW = 7;   // step counter

  localparam logic [MD_CW-1:0] MD_MUL_STEPS = 7'd32;
  localparam logic [MD_CW-1:0] MD_DIV_LONG  = 7'd80;
  localparam logic [MD_CW-1:0] MD_DIV_SHORT = 7'd64;

  localparam logic [31:0] VMAX         = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT    = 32'h8000_0000;
  localparam logic [31:0] BUDGET_RESET = 32'd1000000;

  localparam logic [MD_AW-1:0] K_1E7  = 48'd10000000;
  localparam logic [MD_AW-1:0] K_1E14 = 48'd100000000000000;
  localparam logic [MD_DW-1:0] K_US   = 37'd1000000;
  localparam logic [MD_DW-1:0] K_US5  = 37'd5000000;
  localparam logic [MD_DW-1:0] K_3    = 37'd3;

  localparam logic [0:0] CFG_TARGET = 1'b0;
  localparam logic [0:0] CFG_BUDGET = 1'b1;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_CANCEL = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_RUN      = 2'd0,
    ST_GOAL     = 2'd1,
    ST_CANCELED = 2'd2,
    ST_IDLE     = 2'd3
  } status_t;

  // quotient clamp
  typedef enum logic [1:0] {
    CAP_V = 2'd0,  // 0x7FFFFFFF
    CAP_W = 2'd1,  // 0xFFFFFFFF
    CAP_Q = 2'd2   // full 64 bits
  } cap_t;

  typedef struct packed {
    logic start;
    logic skip_mul;  // dividend is {a, b} as given
    logic short_n;   // dividend fits 64 bits
    cap_t cap;
  } md_req_t;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL,
    MD_ALIGN,
    MD_DIV,
    MD_SAT,
    MD_DONE
  } md_state_t;

  typedef enum logic [3:0] {
    T_IDLE,
    T_PEAK,
    T_ACC1,
    T_ACC2,
    T_RAMP,
    T_PREP,
    T_VACC,
    T_VDEC,
    T_STEP,
    T_PUT1,
    T_PUT2
  } tvp_state_t;

endpackage

FILE: rtl/core/tvp_muldiv.sv
// Bit-serial multiply then restoring divide, floor(a*b/d) with a clamp.
module tvp_muldiv import tvp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  md_req_t          req,
  input  logic [MD_AW-1:0] a,
  input  logic [MD_BW-1:0] b,
  input  logic [MD_DW-1:0] d,
  output logic             done,
  output logic [MD_QW-1:0] q
);

  md_state_t        st_r, st_nxt;
  logic [MD_CW-1:0] cnt_r;
  logic [MD_AW-1:0] a_r;
  logic [MD_DW-1:0] d_r;
  logic [MD_NW-1:0] p_r;
  logic [MD_RW-1:0] rem_r;
  logic [MD_QW-1:0] q_r;
  logic [MD_QW-1:0] res_r;
  logic             ovf_r;
  cap_t             cap_r;
  logic             short_r;

  logic [MD_AW:0]   mul_sum;
  logic [MD_NW-1:0] p_mul;
  logic [MD_RW:0]   rem_sh;
  logic             ge;
  logic [MD_RW-1:0] rem_nxt;
  logic [MD_QW-1:0] cap_val;
  logic [MD_QW-1:0] q_sat;

  // multiply: add multiplicand into the upper half, shift right
  always_comb begin
    mul_sum = {1'b0, p_r[MD_NW-1:MD_BW]} + {1'b0, (p_r[0] ? a_r : {MD_AW{1'b0}})};
    p_mul   = {mul_sum, p_r[MD_BW-1:1]};
  end

  // divide: one quotient bit per step, dividend shifted out MSB first
  always_comb begin
    rem_sh  = {rem_r, p_r[MD_NW-1]};
    ge      = rem_sh >= {2'b00, d_r};
    rem_nxt = ge ? MD_RW'(rem_sh - {2'b00, d_r}) : rem_sh[MD_RW-1:0];
  end

  always_comb begin
    unique case (cap_r)
      CAP_V:   cap_val = {32'h0, VMAX};
      CAP_W:   cap_val = 64'h0000_0000_FFFF_FFFF;
      default: cap_val = {MD_QW{1'b1}};
    endcase
    q_sat = (ovf_r || (q_r > cap_val)) ? cap_val : q_r;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      MD_IDLE:  if (req.start) st_nxt = req.skip_mul ? MD_ALIGN : MD_MUL;
      MD_MUL:   if (cnt_r == MD_CW'(1)) st_nxt = MD_ALIGN;
      MD_ALIGN: st_nxt = MD_DIV;
      MD_DIV:   if (cnt_r == MD_CW'(1)) st_nxt = MD_SAT;
      MD_SAT:   st_nxt = MD_DONE;
      MD_DONE:  st_nxt = MD_IDLE;
      default:  st_nxt = MD_IDLE;
    endcase
  end

  always_comb begin
    done = (st_r == MD_DONE);
    q    = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= MD_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      MD_IDLE: begin
        if (req.start) begin
          a_r     <= a;
          d_r     <= d;
          cap_r   <= req.cap;
          short_r <= req.short_n;
          p_r     <= req.skip_mul ? {a, b} : {{MD_AW{1'b0}}, b};
          cnt_r   <= MD_MUL_STEPS;
        end
      end
      MD_MUL: begin
        p_r   <= p_mul;
        cnt_r <= cnt_r - MD_CW'(1);
      end
      MD_ALIGN: begin
        // short dividends have zero upper bits; skip them
        p_r   <= short_r ? {p_r[MD_QW-1:0], {(MD_NW-MD_QW){1'b0}}} : p_r;
        cnt_r <= short_r ? MD_DIV_SHORT : MD_DIV_LONG;
        rem_r <= '0;
        q_r   <= '0;
        ovf_r <= 1'b0;
      end
      MD_DIV: begin
        p_r   <= {p_r[MD_NW-2:0], 1'b0};
        rem_r <= rem_nxt;
        q_r   <= {q_r[MD_QW-2:0], ge};
        ovf_r <= ovf_r | q_r[MD_QW-1];
        cnt_r <= cnt_r - MD_CW'(1);
      end
      MD_SAT:  res_r <= q_sat;
      MD_DONE: ;
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/trapezoid_velocity_profile.sv
// Top level: trapezoidal velocity profile sequencer for one axis.
// Work per input word: a start word runs four serial mul/div ops; a tick while moving runs
//   one (cruise) or two (accelerate, decelerate); other words run none.
// Throughput: one input word at a time; the next is taken once the last result
//   of the current word sits in the output register. Set by the shared bit-serial unit.
// Reset: synchronous active-low rst_n; idle, no move, target 0, budget 1000000 us.
`include "trapezoid_velocity_profile_macros.svh"

module trapezoid_velocity_profile import tvp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // config
  input  logic               cfg_wr_en,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // input words
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [31:0]        in_elapsed_us,
  // result words
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_drive_velocity,
  output logic signed [31:0] out_position_now,
  output logic [1:0]         out_status,
  output logic               out_last_of_run
);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  tvp_state_t  state_r, state_nxt;
  logic        issued_r;         // current op has been handed to the unit

  logic [31:0] target_r;         // config, signed
  logic [31:0] budget_cfg_r;     // config, us

  logic [31:0] g_r;              // |target| latched at start
  logic        neg_r;            // direction of the move
  logic [31:0] bud_r;            // budget latched at start, zero taken as 1
  logic [30:0] peak_r;
  logic [30:0] accel_r;
  logic [30:0] ramp_r;
  logic [31:0] covered_r;
  logic [31:0] prev_r;
  logic        moving_r;

  logic [31:0] t_r;              // elapsed time of the current tick
  logic [63:0] q1_r;             // first acceleration quotient
  logic [34:0] a5_r;             // 5*t
  logic [33:0] b3_r;             // 3*T
  logic [31:0] dt_r;             // |t - prev|
  logic        back_r;           // time went backwards
  logic [30:0] v_r;              // velocity magnitude of this word
  status_t     put_st_r;         // status of the first result
  logic        tick_run_r;       // first result is a running tick

  logic        out_valid_r;
  logic [31:0] out_vel_r;
  logic [31:0] out_pos_r;
  logic [1:0]  out_status_r;
  logic        out_last_r;

  // ---------------------------------------------------------------------------
  // Arithmetic unit
  // ---------------------------------------------------------------------------
  md_req_t          md_req;
  logic [MD_AW-1:0] md_a;
  logic [MD_BW-1:0] md_b;
  logic [MD_DW-1:0] md_d;
  logic             md_done;
  logic [MD_QW-1:0] md_q;

  tvp_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .a     (md_a),
    .b     (md_b),
    .d     (md_d),
    .done  (md_done),
    .q     (md_q)
  );

  // ---------------------------------------------------------------------------
  // Shared combinational terms
  // ---------------------------------------------------------------------------
  logic        accepted;
  logic        out_free;
  logic        put_load;
  logic        op_state;
  logic [31:0] ramp32;
  logic        acc_zone;
  logic        dec_zone;
  logic        dec_neg;
  logic [34:0] dec_dist;
  logic [31:0] target_mag;
  logic        done_now;
  logic [31:0] spos;
  logic [31:0] sneg_c;
  logic [31:0] term;
  logic [31:0] peak32;
  logic [32:0] dec_sum;
  logic [31:0] dec_diff;
  logic [32:0] dec_raw;
  logic [30:0] dec_v;
  logic [32:0] cov_sum;
  logic [31:0] cov_fwd;
  logic [31:0] cov_back;

  always_comb begin
    out_free   = !out_valid_r || out_ready;
    accepted   = in_valid && in_ready;
    ramp32     = {1'b0, ramp_r};
    // phase from distance covered so far
    acc_zone   = covered_r <= ramp32;
    dec_zone   = (g_r - ramp32) < covered_r;
    // decel term sign: before the 0.6*T point the term is negative
    dec_neg    = a5_r < {1'b0, b3_r};
    dec_dist   = dec_neg ? ({1'b0, b3_r} - a5_r) : (a5_r - {1'b0, b3_r});
    target_mag = target_r[31] ? (32'd0 - target_r) : target_r;
    done_now   = tick_run_r && (covered_r >= g_r);
    // signed position, clamped to the 32-bit signed range
    sneg_c     = (covered_r > NEG_LIMIT) ? NEG_LIMIT : covered_r;
    if (neg_r) begin
      spos = 32'd0 - sneg_c;
    end else begin
      spos = covered_r[31] ? VMAX : covered_r;
    end
    // decelerate: v = |peak - term| with a signed term
    term     = md_q[31:0];
    peak32   = {1'b0, peak_r};
    dec_sum  = {1'b0, peak32} + {1'b0, term};
    dec_diff = (term >= peak32) ? (term - peak32) : (peak32 - term);
    dec_raw  = dec_neg ? dec_sum : {1'b0, dec_diff};
    dec_v    = (dec_raw > {1'b0, VMAX}) ? VMAX[30:0] : dec_raw[30:0];
    // covered update: saturate up, floor at zero going back
    cov_sum  = {1'b0, covered_r} + {1'b0, term};
    cov_fwd  = cov_sum[32] ? 32'hFFFF_FFFF : cov_sum[31:0];
    cov_back = (term > covered_r) ? 32'd0 : (covered_r - term);
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: begin
        if (in_valid) begin
          unique case (kind_t'(in_kind))
            KIND_START:  state_nxt = T_PEAK;
            KIND_TICK:   state_nxt = moving_r ? T_PREP : T_PUT1;
            KIND_CANCEL: state_nxt = T_PUT1;
            KIND_NONE:   state_nxt = T_IDLE;
            default:     state_nxt = T_IDLE;
          endcase
        end
      end
      T_PEAK: if (md_done) state_nxt = T_ACC1;
      T_ACC1: if (md_done) state_nxt = T_ACC2;
      T_ACC2: if (md_done) state_nxt = T_RAMP;
      T_RAMP: if (md_done) state_nxt = T_PUT1;
      T_PREP: begin
        priority if (acc_zone) state_nxt = T_VACC;
        else if (dec_zone)     state_nxt = T_VDEC;
        else                   state_nxt = T_STEP;
      end
      T_VACC: if (md_done) state_nxt = T_STEP;
      T_VDEC: if (md_done) state_nxt = T_STEP;
      T_STEP: if (md_done) state_nxt = T_PUT1;
      T_PUT1: if (out_free) state_nxt = done_now ? T_PUT2 : T_IDLE;
      T_PUT2: if (out_free) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs of the sequencer: handshake and unit requests
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready = (state_r == T_IDLE);
    put_load = ((state_r == T_PUT1) || (state_r == T_PUT2)) && out_free;
    op_state = 1'b0;
    md_req   = '{start: 1'b0, skip_mul: 1'b0, short_n: 1'b1, cap: CAP_V};
    md_a     = '0;
    md_b     = '0;
    md_d     = K_US;
    unique case (state_r)
      T_PEAK: begin
        // peak = g*1e7 / (6T)
        op_state   = 1'b1;
        md_a       = K_1E7;
        md_b       = g_r;
        md_d       = MD_DW'({bud_r, 2'b00}) + MD_DW'({bud_r, 1'b0});
      end
      T_ACC1: begin
        // g*1e14 / (24T), kept to 64 bits
        op_state       = 1'b1;
        md_req.short_n = 1'b0;
        md_req.cap     = CAP_Q;
        md_a           = K_1E14;
        md_b           = g_r;
        md_d           = MD_DW'({bud_r, 4'b0000}) + MD_DW'({bud_r, 3'b000});
      end
      T_ACC2: begin
        // accel = q1 / T
        op_state        = 1'b1;
        md_req.skip_mul = 1'b1;
        md_a            = MD_AW'(q1_r[63:32]);
        md_b            = q1_r[31:0];
        md_d            = MD_DW'(bud_r);
      end
      T_RAMP: begin
        op_state        = 1'b1;
        md_req.skip_mul = 1'b1;
        md_req.cap      = CAP_W;
        md_b            = g_r;
        md_d            = K_3;
      end
      T_VACC: begin
        // v = accel*t / 1e6
        op_state = 1'b1;
        md_a     = MD_AW'(accel_r);
        md_b     = t_r;
        md_d     = K_US;
      end
      T_VDEC: begin
        // term = accel*|5t - 3T| / 5e6
        op_state       = 1'b1;
        md_req.short_n = 1'b0;
        md_req.cap     = CAP_W;
        md_a           = MD_AW'(dec_dist);
        md_b           = {1'b0, accel_r};
        md_d           = K_US5;
      end
      T_STEP: begin
        // distance step = v*dt / 1e6
        op_state   = 1'b1;
        md_req.cap = CAP_W;
        md_a       = MD_AW'(v_r);
        md_b       = dt_r;
        md_d       = K_US;
      end
      default: ;
    endcase
    md_req.start = op_state && !issued_r;
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      issued_r     <= 1'b0;
      target_r     <= '0;
      budget_cfg_r <= BUDGET_RESET;
      moving_r     <= 1'b0;
      g_r          <= '0;
      neg_r        <= 1'b0;
      bud_r        <= '0;
      peak_r       <= '0;
      accel_r      <= '0;
      ramp_r       <= '0;
      covered_r    <= '0;
      prev_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) begin
        if (cfg_index == CFG_TARGET) target_r     <= cfg_data;
        if (cfg_index == CFG_BUDGET) budget_cfg_r <= cfg_data;
      end

      if (op_state) begin
        issued_r <= md_done ? 1'b0 : (issued_r | md_req.start);
      end

      if (accepted) begin
        unique case (kind_t'(in_kind))
          KIND_START: begin
            neg_r     <= target_r[31];
            g_r       <= target_mag;
            bud_r     <= (budget_cfg_r == 32'd0) ? 32'd1 : budget_cfg_r;
            covered_r <= '0;
            prev_r    <= '0;
            moving_r  <= (target_mag != 32'd0);
          end
          KIND_CANCEL: moving_r <= 1'b0;
          default: ;
        endcase
      end

      if (md_done) begin
        unique case (state_r)
          T_PEAK: peak_r  <= md_q[30:0];
          T_ACC2: accel_r <= md_q[30:0];
          T_RAMP: ramp_r  <= md_q[30:0];
          T_STEP: begin
            covered_r <= back_r ? cov_back : cov_fwd;
            prev_r    <= t_r;
          end
          default: ;
        endcase
      end

      if ((state_r == T_PUT1) && out_free && done_now) moving_r <= 1'b0;

      if (put_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk) begin
    if (accepted) begin
      t_r <= in_elapsed_us;
      v_r <= '0;
      unique case (kind_t'(in_kind))
        KIND_START: begin
          put_st_r   <= (target_mag != 32'd0) ? ST_RUN : ST_GOAL;
          tick_run_r <= 1'b0;
        end
        KIND_TICK: begin
          put_st_r   <= moving_r ? ST_RUN : ST_IDLE;
          tick_run_r <= moving_r;
        end
        default: begin
          put_st_r   <= moving_r ? ST_CANCELED : ST_IDLE;
          tick_run_r <= 1'b0;
        end
      endcase
    end

    if (state_r == T_PREP) begin
      a5_r   <= 35'({t_r, 2'b00}) + 35'(t_r);
      b3_r   <= 34'({bud_r, 1'b0}) + 34'(bud_r);
      back_r <= t_r < prev_r;
      dt_r   <= (t_r < prev_r) ? (prev_r - t_r) : (t_r - prev_r);
      if (!acc_zone && !dec_zone) v_r <= peak_r;   // cruise
    end

    if (md_done) begin
      unique case (state_r)
        T_ACC1: q1_r <= md_q;
        T_VACC: v_r  <= md_q[30:0];
        T_VDEC: v_r  <= dec_v;
        default: ;
      endcase
    end

    if (put_load) begin
      out_pos_r <= spos;
      if (state_r == T_PUT1) begin
        out_vel_r    <= neg_r ? (32'd0 - {1'b0, v_r}) : {1'b0, v_r};
        out_status_r <= put_st_r;
        out_last_r   <= !done_now;
      end else begin
        out_vel_r    <= '0;
        out_status_r <= ST_GOAL;
        out_last_r   <= 1'b1;
      end
    end
  end

  always_comb begin
    out_valid          = out_valid_r;
    out_drive_velocity = out_vel_r;
    out_position_now   = out_pos_r;
    out_status         = out_status_r;
    out_last_of_run    = out_last_r;
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  logic run_taken;   // running word with a goal word behind it leaves
  logic goal_shown;  // goal word on the output

  always_comb begin
    run_taken  = out_valid_r && out_ready && !out_last_r;
    goal_shown = out_valid_r && (out_status_r == ST_GOAL) && out_last_r;
  end

  `TVP_ASSERT_IMP(a_done_only_issued, md_done, issued_r, "unit done with no op issued")
  `TVP_ASSERT_NXT(a_goal_follows, run_taken, goal_shown, "goal word missing after run word")
  `TVP_ASSERT_IMP(a_moving_has_goal, moving_r, g_r != 32'd0, "moving with zero goal")

endmodule
